// ===== hw/rtl/srtf_pkg.sv =====
`timescale 1ns / 1ps

package srtf_pkg;

  // table size and derived widths
  localparam int MAX_JOBS = 16;
  localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);

  // fixed field widths
  localparam int BURST_W  = 16;
  localparam int TIME_W   = 32;
  localparam int JOB_ID_W = 4;
  localparam int CFG_W    = 16;

  // stream word widths
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 1;
  localparam int OUT_RAW_W  = JOB_ID_W + 3 * TIME_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_RAW_W;
  localparam int OUT_USER_W = 3;

  // input kinds
  localparam logic MODE_ARRIVE = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  // value loaded into the time counter at reset
  localparam logic [TIME_W-1:0] START_TIME_RST = '0;

  // search token passed down the cell chain
  typedef struct packed {
    logic               vld;
    logic               found;
    logic [IDX_W-1:0]   idx;
    logic [BURST_W-1:0] rem;
    logic [BURST_W-1:0] burst;
    logic [TIME_W-1:0]  arr;
  } tok_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic               wr;
    logic               dec;
    logic [IDX_W-1:0]   sel;
    logic [BURST_W-1:0] burst;
    logic [TIME_W-1:0]  stamp;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/srtf_cell.sv =====
`timescale 1ns / 1ps

module srtf_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [srtf_pkg::IDX_W-1:0] cell_idx,
  input  logic                       occ,
  input  srtf_pkg::cell_ctl_t        ctl,
  input  srtf_pkg::tok_t             tok_in,
  output srtf_pkg::tok_t             tok_out
);
  import srtf_pkg::*;

  logic [BURST_W-1:0] rem_r;
  logic [BURST_W-1:0] burst_r;
  logic [TIME_W-1:0]  arr_r;
  logic               vld_r;
  tok_t               tok_r;
  tok_t               tok_nxt;
  logic               hit;
  logic               take;

  assign hit = (ctl.sel == cell_idx);

  // job slot: load on arrival, count down when it runs
  always_ff @(posedge clk) begin
    if (ctl.wr && hit) begin
      rem_r   <= ctl.burst;
      burst_r <= ctl.burst;
      arr_r   <= ctl.stamp;
    end else if (ctl.dec && hit) begin
      rem_r <= rem_r - BURST_W'(1);
    end
  end

  // strict less-than keeps the lower-numbered job on a tie
  assign take = occ && (rem_r != '0) && (!tok_in.found || (rem_r < tok_in.rem));

  always_comb begin
    tok_nxt = tok_in;
    if (take) begin
      tok_nxt.found = 1'b1;
      tok_nxt.idx   = cell_idx;
      tok_nxt.rem   = rem_r;
      tok_nxt.burst = burst_r;
      tok_nxt.arr   = arr_r;
    end
  end

  // token stage: valid is reset, payload is not
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= tok_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  always_comb begin
    tok_out     = tok_r;
    tok_out.vld = vld_r;
  end

endmodule

// ===== hw/rtl/srtf_job_scheduler_top.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Handshake             Word
// in_      in   in_tvalid/in_tready   tdata: burst_length; tuser: mode
// out_     out  out_tvalid/out_tready tdata: job_id, finish_time, turnaround, waiting
// cfg_     in   cfg_valid/cfg_ready   cfg_data: start_time
//
// Arrive word: S_IDLE, S_OUT, output register. Tick word: S_SCAN, S_CALC0, S_CALC1 if the
// job finishes, S_OUT, output register; the search token walks one cell per cycle.
// One word is in flight at a time; the next is accepted once the result is in the output
// register. rst_n (synchronous) empties the table and loads the time counter with 0.
// cfg_ready is high only while no word is being worked on.
// A stalled out_tready holds the result register; the next word still runs, then waits for
// the register and keeps in_tready low until it is moved.

module srtf_job_scheduler_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // cfg
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [srtf_pkg::CFG_W-1:0]       cfg_data,
  // in
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [srtf_pkg::IN_DATA_W-1:0]   in_tdata,   // [15:0] burst_length
  input  logic [srtf_pkg::IN_USER_W-1:0]   in_tuser,   // [0] mode
  // out
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [srtf_pkg::OUT_DATA_W-1:0]  out_tdata,  // [3:0] job_id, [35:4] finish_time,
                                                       // [67:36] turnaround, [99:68] waiting
  output logic [srtf_pkg::OUT_USER_W-1:0]  out_tuser   // [0] accepted, [1] ran, [2] finished
);
  import srtf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_CALC0 = 5'b00100,
    S_CALC1 = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;

  // pending result
  logic                res_acc_r, res_ran_r, res_fin_r;
  logic [JOB_ID_W-1:0] res_id_r;
  logic [TIME_W-1:0]   fin_r, tat_r, wt_r;
  logic [BURST_W-1:0]  hold_burst_r;
  logic [TIME_W-1:0]   hold_arr_r;

  // output register
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [OUT_USER_W-1:0] out_tuser_r;

  logic      in_acc;
  logic      arrive;
  logic      tick;
  logic      full;
  logic      scan_done;
  logic      out_load;
  cell_ctl_t ctl;
  tok_t      tok_chain [MAX_JOBS+1];
  tok_t      tok_tail;
  logic [MAX_JOBS-1:0] occ;

  assign cfg_ready = (state_r == S_IDLE);
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign arrive    = in_acc && (in_tuser[0] == MODE_ARRIVE);
  assign tick      = in_acc && (in_tuser[0] == MODE_TICK);
  assign full      = (cnt_r == CNT_W'(MAX_JOBS));
  assign tok_tail  = tok_chain[MAX_JOBS];
  assign scan_done = (state_r == S_SCAN) && tok_tail.vld;
  assign out_load  = (state_r == S_OUT) && (!out_tvalid_r || out_tready);

  // head of the chain: fresh token on a tick
  always_comb begin
    tok_chain[0]       = '0;
    tok_chain[0].vld   = tick;
    tok_chain[0].found = 1'b0;
  end

  // broadcast to the cells
  always_comb begin
    ctl.wr    = arrive && !full;
    ctl.dec   = scan_done && tok_tail.found;
    ctl.sel   = ctl.wr ? cnt_r[IDX_W-1:0] : tok_tail.idx;
    ctl.burst = in_tdata[BURST_W-1:0];
    ctl.stamp = time_r;
  end

  // cell chain
  for (genvar k = 0; k < MAX_JOBS; k++) begin : g_cell
    assign occ[k] = (CNT_W'(k) < cnt_r);
    srtf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(k)),
      .occ      (occ[k]),
      .ctl      (ctl),
      .tok_in   (tok_chain[k]),
      .tok_out  (tok_chain[k+1])
    );
  end

  // control next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    time_nxt  = time_r;
    case (state_r)
      S_IDLE: begin
        if (cfg_valid && cfg_ready) begin
          time_nxt = TIME_W'(cfg_data);
        end
        if (arrive) begin
          if (!full) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          state_nxt = S_OUT;
        end else if (tick) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tok_tail.vld) begin
          time_nxt = time_r + TIME_W'(1);
          if (tok_tail.found && (tok_tail.rem == BURST_W'(1))) begin
            state_nxt = S_CALC0;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_CALC0: state_nxt = S_CALC1;
      S_CALC1: state_nxt = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      time_r  <= START_TIME_RST;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      time_r  <= time_nxt;
    end
  end

  // result fields; time_r already holds the finish time in the calc states
  always_ff @(posedge clk) begin
    if (arrive) begin
      res_acc_r <= !full;
      res_id_r  <= full ? '0 : JOB_ID_W'(cnt_r);
      res_ran_r <= 1'b0;
      res_fin_r <= 1'b0;
      fin_r     <= '0;
      tat_r     <= '0;
      wt_r      <= '0;
    end else if (scan_done) begin
      res_acc_r    <= 1'b0;
      res_id_r     <= tok_tail.found ? JOB_ID_W'(tok_tail.idx) : '0;
      res_ran_r    <= tok_tail.found;
      res_fin_r    <= tok_tail.found && (tok_tail.rem == BURST_W'(1));
      hold_burst_r <= tok_tail.burst;
      hold_arr_r   <= tok_tail.arr;
      fin_r        <= '0;
      tat_r        <= '0;
      wt_r         <= '0;
    end else if (state_r == S_CALC0) begin
      fin_r <= time_r;
      tat_r <= time_r - hold_arr_r;
    end else if (state_r == S_CALC1) begin
      wt_r <= tat_r - TIME_W'(hold_burst_r);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {{OUT_PAD_W{1'b0}}, wt_r, tat_r, fin_r, res_id_r};
      out_tuser_r <= {res_fin_r, res_ran_r, res_acc_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // checks
  a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
    tick |-> ##MAX_JOBS tok_tail.vld)
    else $error("search token did not reach the chain end in time");

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_JOBS))
    else $error("job count beyond table size");

  a_fin_ran: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (!out_tuser_r[2] || out_tuser_r[1]))
    else $error("finished reported without a run");

  a_acc_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> !(out_tuser_r[0] && out_tuser_r[1]))
    else $error("accepted and ran in one result");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=> (cnt_r == $past(cnt_r)))
    else $error("job count moved outside an arrival");

endmodule

// ===== tb/srtf_checker.sv =====
`timescale 1ns / 1ps

// Watches the config, input and result channels of the scheduler, keeps its own
// copy of the job table and time counter, and compares every result word against
// the oldest predicted one.
module srtf_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [srtf_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [srtf_pkg::IN_DATA_W-1:0]  in_tdata,   // [15:0] burst_length
  input  logic [srtf_pkg::IN_USER_W-1:0]  in_tuser,   // [0] mode
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [srtf_pkg::OUT_DATA_W-1:0] out_tdata,  // [3:0] job_id, [35:4] finish_time,
                                                      // [67:36] turnaround, [99:68] waiting
  input  logic [srtf_pkg::OUT_USER_W-1:0] out_tuser,  // [0] accepted, [1] ran, [2] finished
  output int                              fail_count,
  output int                              words_pending
);
  import srtf_pkg::*;

  // field offsets inside out_tdata
  localparam int FIN_LSB  = JOB_ID_W;
  localparam int TAT_LSB  = JOB_ID_W + TIME_W;
  localparam int WAIT_LSB = JOB_ID_W + 2 * TIME_W;

  typedef struct packed {
    logic                accepted;
    logic [JOB_ID_W-1:0] job_id;
    logic                ran;
    logic                finished;
    logic [TIME_W-1:0]   finish_time;
    logic [TIME_W-1:0]   turnaround;
    logic [TIME_W-1:0]   waited;
  } sched_result_t;

  // scheduler state as seen from outside
  logic [BURST_W-1:0] time_left [MAX_JOBS];
  logic [BURST_W-1:0] burst_len [MAX_JOBS];
  logic [TIME_W-1:0]  arrived_at [MAX_JOBS];
  int unsigned        jobs_stored;
  logic [TIME_W-1:0]  clock_now;

  sched_result_t results_due[$];
  sched_result_t next_due;

  initial begin
    fail_count    = 0;
    words_pending = 0;
    jobs_stored   = 0;
    clock_now     = START_TIME_RST;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [TIME_W-1:0] got,
                             input logic [TIME_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  // one arrive or tick word: update the table and work out its result
  task automatic schedule_word(input logic mode, input logic [BURST_W-1:0] burst,
                               output sched_result_t res);
    sched_result_t      r;
    int unsigned        best;
    logic [BURST_W-1:0] best_rem;
    logic               found;
    logic [TIME_W-1:0]  done_at;
    r        = '0;
    best     = 0;
    best_rem = '0;
    found    = 1'b0;
    if (mode == MODE_ARRIVE) begin
      // full table drops the job and leaves state alone
      if (jobs_stored < MAX_JOBS) begin
        time_left[jobs_stored]  = burst;
        burst_len[jobs_stored]  = burst;
        arrived_at[jobs_stored] = clock_now;
        r.accepted = 1'b1;
        r.job_id   = JOB_ID_W'(jobs_stored);
        jobs_stored++;
      end
    end else begin
      // smallest nonzero remaining time, lowest number wins ties
      for (int unsigned i = 0; i < jobs_stored; i++) begin
        if (time_left[i] != '0 && (!found || time_left[i] < best_rem)) begin
          best     = i;
          best_rem = time_left[i];
          found    = 1'b1;
        end
      end
      if (found) begin
        time_left[best] = best_rem - 1'b1;
        r.job_id = JOB_ID_W'(best);
        r.ran    = 1'b1;
        if (time_left[best] == '0) begin
          done_at       = clock_now + 1'b1;
          r.finished    = 1'b1;
          r.finish_time = done_at;
          r.turnaround  = done_at - arrived_at[best];
          r.waited      = r.turnaround - TIME_W'(burst_len[best]);
        end
      end
      clock_now = clock_now + 1'b1;
    end
    res = r;
  endtask

  task automatic check_result();
    sched_result_t want;
    if (results_due.size() == 0) begin
      report_mismatch($sformatf("result word with nothing pending, tdata 0x%0h", out_tdata));
    end else begin
      want = results_due.pop_front();
      check_field("accepted", out_tuser[0], want.accepted);
      check_field("ran", out_tuser[1], want.ran);
      check_field("finished", out_tuser[2], want.finished);
      check_field("job_id", out_tdata[JOB_ID_W-1:0], want.job_id);
      check_field("finish_time", out_tdata[FIN_LSB +: TIME_W], want.finish_time);
      check_field("turnaround", out_tdata[TAT_LSB +: TIME_W], want.turnaround);
      check_field("waiting", out_tdata[WAIT_LSB +: TIME_W], want.waited);
      check_field("tdata pad", TIME_W'(out_tdata >> OUT_RAW_W), '0);
    end
  endtask

  // result side first: a word leaving now belongs to an earlier input
  always @(posedge clk) begin
    if (!rst_n) begin
      jobs_stored = 0;
      clock_now   = START_TIME_RST;
      results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        clock_now = TIME_W'(cfg_data);
      end
      if (out_tvalid && out_tready) begin
        check_result();
      end
      if (in_tvalid && in_tready) begin
        schedule_word(in_tuser[0], in_tdata[BURST_W-1:0], next_due);
        results_due.insert(results_due.size(), next_due);
      end
    end
    words_pending = results_due.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import srtf_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 6;
  localparam int LONG_HOLD     = 400;
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_WORDS   = 106;
  localparam int DRAIN_CYCLES  = 2 * (MAX_JOBS + 4);

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [15:0] burst_length
  logic [IN_USER_W-1:0]  in_tuser;   // [0] mode
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [3:0] job_id, [35:4] finish_time,
                                     // [67:36] turnaround, [99:68] waiting
  logic [OUT_USER_W-1:0] out_tuser;  // [0] accepted, [1] ran, [2] finished

  int   fail_count;
  int   words_pending;
  int   idle_cycles = 0;
  int   slots_used;
  int   burst_left;
  logic hold_req;

  srtf_job_scheduler_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  srtf_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // watchdog: too long without any word moving on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side backpressure: random segments, plus one long hold on request
  initial begin
    int   seg_left;
    int   seg_kind;
    logic hold_done;
    seg_left   = 0;
    seg_kind   = 0;
    hold_done  = 1'b0;
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_done = 1'b1;
        out_tready <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(16, 160);
          seg_kind = $urandom_range(0, 3);
        end
        seg_left--;
        case (seg_kind)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ($urandom_range(0, 5) == 0);
          default: out_tready <= seg_left[1];
        endcase
      end
    end
  end

  // one input word; valid stays up after acceptance unless a gap follows
  task automatic send_word(input logic mode, input logic [BURST_W-1:0] burst, input int gap);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= burst;
    do @(posedge clk); while (!in_tready);
    if (mode == MODE_ARRIVE && slots_used < MAX_JOBS) begin
      slots_used++;
    end
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic write_start_time(input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
  endtask

  // mostly ticks; arrivals get mostly short bursts while the table still has room
  task automatic send_random_word();
    logic               mode;
    logic [BURST_W-1:0] burst;
    int                 gap;
    if (slots_used < MAX_JOBS) begin
      mode = ($urandom_range(0, 9) == 0) ? MODE_ARRIVE : MODE_TICK;
    end else begin
      mode = ($urandom_range(0, 7) == 0) ? MODE_ARRIVE : MODE_TICK;
    end
    if (mode == MODE_ARRIVE && slots_used < MAX_JOBS) begin
      burst = ($urandom_range(0, 5) == 0) ? BURST_W'($urandom_range(25, 300))
                                          : BURST_W'($urandom_range(1, 24));
    end else begin
      burst = BURST_W'($urandom_range(0, 65535));
    end
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    if (burst_left != 0) begin
      gap = 0;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
    end
    send_word(mode, burst, gap);
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = MODE_ARRIVE;
    hold_req   = 1'b0;
    slots_used = 0;
    burst_left = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty table right after reset: idle tick at the reset start time
    send_word(MODE_TICK, 16'h0000, 1);
    drain_results();
    write_start_time(16'hFFFF);

    // idle tick, zero burst that never runs, max burst, tie on equal bursts, a new arrival tying with a running job
    send_word(MODE_TICK, 16'hFFFF, $urandom_range(0, 2));
    send_word(MODE_ARRIVE, 16'h0000, $urandom_range(0, 2));
    send_word(MODE_TICK, 16'h5A5A, $urandom_range(0, 2));
    send_word(MODE_ARRIVE, 16'hFFFF, $urandom_range(0, 2));
    send_word(MODE_ARRIVE, 16'h0001, $urandom_range(0, 2));
    send_word(MODE_ARRIVE, 16'h0001, $urandom_range(0, 2));
    send_word(MODE_TICK, 16'h0000, $urandom_range(0, 2));
    send_word(MODE_ARRIVE, 16'h0003, $urandom_range(0, 2));
    send_word(MODE_ARRIVE, 16'h0002, $urandom_range(0, 2));
    send_word(MODE_TICK, 16'hA5A5, $urandom_range(0, 2));
    send_word(MODE_TICK, 16'h0000, $urandom_range(0, 2));
    send_word(MODE_ARRIVE, 16'h0001, $urandom_range(0, 2));
    send_word(MODE_TICK, 16'h0000, $urandom_range(0, 2));

    // pull time back below the stored stamps: turnaround and waiting wrap
    drain_results();
    write_start_time(16'h0000);
    repeat (5) send_word(MODE_TICK, 16'h0000, $urandom_range(0, 2));

    // random phases, each from its own start time
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_results();
      write_start_time(CFG_W'($urandom_range(0, 65535)));
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (p == 1 && n == 20) begin
          hold_req = 1'b1;
        end
        send_random_word();
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
